>>> hdl/sle_pkg.sv
// sle_pkg: shared widths, operation and status codes, and the cell control
// struct for the sequential list engine; no dependencies
`default_nettype none

package sle_pkg;

   // list geometry; the depth is set directly and the index width follows from it
   localparam int SLE_DEPTH      = 64;
   localparam int SLE_IDX_W      = $clog2(SLE_DEPTH);
   localparam int SLE_CNT_W      = 7;
   localparam int SLE_WORD_WIDTH = 32;

   // field widths of the request and response channels
   localparam int SLE_OPCODE_W = 3;
   localparam int SLE_POS_W    = 7;
   localparam int SLE_VALUE_W  = 32;
   localparam int SLE_STATUS_W = 2;

   // operation codes as they arrive on the request channel
   typedef enum logic [SLE_OPCODE_W-1:0] {
      SLE_OP_GET    = 3'd0,
      SLE_OP_SET    = 3'd1,
      SLE_OP_INSERT = 3'd2,
      SLE_OP_DELETE = 3'd3,
      SLE_OP_LOCATE = 3'd4,
      SLE_OP_NONE   = 3'd7
   } sle_op_type;

   // response status codes
   typedef enum logic [SLE_STATUS_W-1:0] {
      SLE_ST_OK       = 2'd0,
      SLE_ST_RANGE    = 2'd1,
      SLE_ST_FULL     = 2'd2,
      SLE_ST_NOTFOUND = 2'd3
   } sle_status_type;

   // control part of the operation token that walks down the cell row
   typedef struct packed {
      logic       active;
      sle_op_type op;
      logic       found;
   } sle_ctl_type;

endpackage

`default_nettype wire

>>> hdl/sle_cell.sv
// sle_cell: one list entry plus one stage of the operation token; applies
// the token's operation to its entry as the token passes; uses sle_pkg
`default_nettype none

module sle_cell #(
   parameter int WORD_WIDTH = sle_pkg::SLE_WORD_WIDTH,
   parameter int INDEX      = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   // token from the left neighbor
   input  sle_pkg::sle_ctl_type            up_ctl,
   input  logic [sle_pkg::SLE_IDX_W-1:0]   up_pos,
   input  logic [sle_pkg::SLE_CNT_W-1:0]   up_cnt,
   input  logic [WORD_WIDTH-1:0]           up_key,
   input  logic [WORD_WIDTH-1:0]           up_word,
   input  logic [sle_pkg::SLE_CNT_W-1:0]   up_fpos,
   // entry held by the right neighbor, for delete shifting
   input  logic [WORD_WIDTH-1:0]           right_data,
   // token to the right neighbor
   output sle_pkg::sle_ctl_type            dn_ctl,
   output logic [sle_pkg::SLE_IDX_W-1:0]   dn_pos,
   output logic [sle_pkg::SLE_CNT_W-1:0]   dn_cnt,
   output logic [WORD_WIDTH-1:0]           dn_key,
   output logic [WORD_WIDTH-1:0]           dn_word,
   output logic [sle_pkg::SLE_CNT_W-1:0]   dn_fpos,
   // this cell's entry, seen by the left neighbor
   output logic [WORD_WIDTH-1:0]           data_out
);
   import sle_pkg::*;

   localparam logic [SLE_CNT_W-1:0] IDX      = SLE_CNT_W'(INDEX);
   localparam logic [SLE_CNT_W-1:0] IDX_NEXT = SLE_CNT_W'(INDEX + 1);

   sle_ctl_type             ctl_ff, ctl_in;
   logic [SLE_IDX_W-1:0]    pos_ff;
   logic [SLE_CNT_W-1:0]    cnt_ff;
   logic [WORD_WIDTH-1:0]   key_ff;
   logic [WORD_WIDTH-1:0]   word_ff, word_in;
   logic [SLE_CNT_W-1:0]    fpos_ff, fpos_in;
   logic [WORD_WIDTH-1:0]   data_ff, data_in;
   logic [SLE_CNT_W-1:0]    pos_ext;
   logic                    at_pos;

   assign pos_ext = SLE_CNT_W'(up_pos);
   assign at_pos  = (pos_ext == IDX);

   // apply the passing operation to this entry
   always_comb begin
      ctl_in  = up_ctl;
      word_in = up_word;
      fpos_in = up_fpos;
      data_in = data_ff;
      if (up_ctl.active) begin
         unique case (up_ctl.op)
            SLE_OP_GET: begin
               if (at_pos) word_in = data_ff;
            end
            SLE_OP_SET: begin
               if (at_pos) data_in = up_key;
            end
            SLE_OP_INSERT: begin
               // new value lands here, later entries take the carried word
               if (at_pos) begin
                  data_in = up_key;
                  word_in = data_ff;
               end else if ((IDX > pos_ext) && (IDX <= up_cnt)) begin
                  data_in = up_word;
                  word_in = data_ff;
               end
            end
            SLE_OP_DELETE: begin
               if (at_pos) word_in = data_ff;
               if ((IDX >= pos_ext) && (IDX_NEXT < up_cnt)) data_in = right_data;
            end
            SLE_OP_LOCATE: begin
               if (!up_ctl.found && (IDX < up_cnt) && (data_ff == up_key)) begin
                  ctl_in.found = 1'b1;
                  fpos_in      = IDX_NEXT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // token control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   // token payload and entry
   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff  <= up_pos;
         cnt_ff  <= up_cnt;
         key_ff  <= up_key;
         word_ff <= word_in;
         fpos_ff <= fpos_in;
         data_ff <= data_in;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_pos   = pos_ff;
   assign dn_cnt   = cnt_ff;
   assign dn_key   = key_ff;
   assign dn_word  = word_ff;
   assign dn_fpos  = fpos_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

>>> hdl/sequential_list_engine.sv
// Response: a request's token passes through the SLE_DEPTH cell registers, then the
// response register. A new request is taken only once that response is loaded; the
// token walks one cell per cycle unless the row is frozen; only one is in flight.
// A response still waiting when the next token reaches the end of the row
// freezes the row until it is taken.
// Reset: synchronous, clears the entry count to zero and the capacity to 64;
// list entries are not cleared.
// sequential_list_engine: top level; request checks, count and capacity
// registers, the cell row and the response register; uses sle_pkg, sle_cell
`default_nettype none

module sequential_list_engine #(
   parameter int WORD_WIDTH = sle_pkg::SLE_WORD_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sle_pkg::SLE_OPCODE_W-1:0]      req_opcode,
   input  logic [sle_pkg::SLE_POS_W-1:0]         req_position,
   input  logic signed [sle_pkg::SLE_VALUE_W-1:0] req_value_in,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sle_pkg::SLE_STATUS_W-1:0]      rsp_status,
   output logic signed [sle_pkg::SLE_VALUE_W-1:0] rsp_value_out,
   output logic [sle_pkg::SLE_POS_W-1:0]         rsp_found_position,
   output logic [sle_pkg::SLE_CNT_W-1:0]         rsp_entry_count,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [sle_pkg::SLE_CNT_W-1:0]         csr_capacity_in_use
);
   import sle_pkg::*;

   localparam logic [SLE_CNT_W-1:0] DEPTH_CNT = SLE_CNT_W'(SLE_DEPTH);

   // token chain between cells; index 0 is the launch point
   sle_ctl_type             chain_ctl  [0:SLE_DEPTH];
   logic [SLE_IDX_W-1:0]    chain_pos  [0:SLE_DEPTH];
   logic [SLE_CNT_W-1:0]    chain_cnt  [0:SLE_DEPTH];
   logic [WORD_WIDTH-1:0]   chain_key  [0:SLE_DEPTH];
   logic [WORD_WIDTH-1:0]   chain_word [0:SLE_DEPTH];
   logic [SLE_CNT_W-1:0]    chain_fpos [0:SLE_DEPTH];
   logic [WORD_WIDTH-1:0]   cell_data  [0:SLE_DEPTH-1];

   logic                    busy_ff, busy_in;
   logic [SLE_CNT_W-1:0]    count_ff, count_in;
   logic [SLE_CNT_W-1:0]    cap_ff;
   logic [SLE_CNT_W-1:0]    cap_eff;
   sle_status_type          pend_status_ff, launch_status;
   sle_op_type              launch_op;
   logic                    accept;
   logic                    advance;
   logic                    rsp_load;
   logic                    pos_nonzero;
   logic                    pos_exists;
   logic                    pos_insertable;
   sle_ctl_type             last_ctl;
   logic signed [WORD_WIDTH-1:0] last_word;
   sle_status_type          final_status;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLE_STATUS_W-1:0] rsp_status_ff;
   logic signed [SLE_VALUE_W-1:0] rsp_value_ff;
   logic [SLE_POS_W-1:0]    rsp_fpos_ff;
   logic [SLE_CNT_W-1:0]    rsp_count_ff;

   // handshake
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign last_ctl  = chain_ctl[SLE_DEPTH];
   assign rsp_load  = last_ctl.active && (!rsp_valid_ff || !rsp_stall);
   assign advance   = !(last_ctl.active && rsp_valid_ff && rsp_stall);

   // effective capacity, limited to the row length
   assign cap_eff = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;

   // position checks against the current count
   assign pos_nonzero    = (req_position != '0);
   assign pos_exists     = pos_nonzero && (req_position <= count_ff);
   assign pos_insertable = pos_nonzero &&
                           ({1'b0, req_position} <= ({1'b0, count_ff} + 8'd1));

   // decode the request into a token operation, a status and the new count
   always_comb begin
      launch_op     = SLE_OP_NONE;
      launch_status = SLE_ST_OK;
      count_in      = count_ff;
      unique case (req_opcode)
         SLE_OP_GET: begin
            if (pos_exists) launch_op = SLE_OP_GET;
            else launch_status = SLE_ST_RANGE;
         end
         SLE_OP_SET: begin
            if (pos_exists) launch_op = SLE_OP_SET;
            else launch_status = SLE_ST_RANGE;
         end
         SLE_OP_INSERT: begin
            priority if (!pos_insertable) begin
               launch_status = SLE_ST_RANGE;
            end else if (count_ff >= cap_eff) begin
               launch_status = SLE_ST_FULL;
            end else begin
               launch_op = SLE_OP_INSERT;
               count_in  = count_ff + 7'd1;
            end
         end
         SLE_OP_DELETE: begin
            if (pos_exists) begin
               launch_op = SLE_OP_DELETE;
               count_in  = count_ff - 7'd1;
            end else begin
               launch_status = SLE_ST_RANGE;
            end
         end
         SLE_OP_LOCATE: begin
            launch_op     = SLE_OP_LOCATE;
            launch_status = SLE_ST_NOTFOUND;
         end
         default: begin
         end
      endcase
   end

   // token launch into the first cell
   always_comb begin
      chain_ctl[0]        = '0;
      chain_ctl[0].active = accept;
      chain_ctl[0].op     = launch_op;
      chain_ctl[0].found  = 1'b0;
   end
   assign chain_pos[0]  = SLE_IDX_W'(req_position - 7'd1);
   assign chain_cnt[0]  = count_ff;
   assign chain_key[0]  = WORD_WIDTH'(req_value_in);
   assign chain_word[0] = '0;
   assign chain_fpos[0] = '0;

   // row of cells
   for (genvar i = 0; i < SLE_DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] right;
      if (i < SLE_DEPTH - 1) begin : g_mid
         assign right = cell_data[i+1];
      end else begin : g_end
         assign right = cell_data[i];
      end
      sle_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .up_ctl     (chain_ctl[i]),
         .up_pos     (chain_pos[i]),
         .up_cnt     (chain_cnt[i]),
         .up_key     (chain_key[i]),
         .up_word    (chain_word[i]),
         .up_fpos    (chain_fpos[i]),
         .right_data (right),
         .dn_ctl     (chain_ctl[i+1]),
         .dn_pos     (chain_pos[i+1]),
         .dn_cnt     (chain_cnt[i+1]),
         .dn_key     (chain_key[i+1]),
         .dn_word    (chain_word[i+1]),
         .dn_fpos    (chain_fpos[i+1]),
         .data_out   (cell_data[i])
      );
   end

   // busy from transfer until the response is loaded
   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (rsp_load) busy_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= DEPTH_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
         if (csr_write_enable) cap_ff <= csr_capacity_in_use;
      end
   end

   // status held while the token walks
   always_ff @(posedge clock) begin
      if (accept) pend_status_ff <= launch_status;
   end

   // response assembly at the end of the row
   assign last_word    = chain_word[SLE_DEPTH];
   assign final_status = (last_ctl.op == SLE_OP_LOCATE)
                         ? (last_ctl.found ? SLE_ST_OK : SLE_ST_NOTFOUND)
                         : pend_status_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= final_status;
         rsp_value_ff  <= ((last_ctl.op == SLE_OP_GET) || (last_ctl.op == SLE_OP_DELETE))
                          ? SLE_VALUE_W'(last_word) : '0;
         rsp_fpos_ff   <= chain_fpos[SLE_DEPTH];
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

`default_nettype wire

>>> sim/sle_list_checker.sv
// sle_list_checker: watches the request, response and csr ports of the list engine,
// predicts every response from its own copy of the list and compares field by field
// depends on sle_pkg for widths, operation and status codes
module sle_list_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [sle_pkg::SLE_OPCODE_W-1:0]       req_opcode,
   input  logic [sle_pkg::SLE_POS_W-1:0]          req_position,
   input  logic signed [sle_pkg::SLE_VALUE_W-1:0] req_value_in,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [sle_pkg::SLE_STATUS_W-1:0]       rsp_status,
   input  logic signed [sle_pkg::SLE_VALUE_W-1:0] rsp_value_out,
   input  logic [sle_pkg::SLE_POS_W-1:0]          rsp_found_position,
   input  logic [sle_pkg::SLE_CNT_W-1:0]          rsp_entry_count,
   input  logic                                   csr_write_enable,
   input  logic [sle_pkg::SLE_CNT_W-1:0]          csr_capacity_in_use,
   output int                                     fail_count,
   output int                                     outstanding
);
   import sle_pkg::*;

   typedef struct packed {
      sle_status_type                status;
      logic signed [SLE_VALUE_W-1:0] value_out;
      logic [SLE_POS_W-1:0]          found_position;
      logic [SLE_CNT_W-1:0]          entry_count;
   } list_result_type;

   // shadow of the list contents, the entry count and the capacity register
   logic signed [SLE_VALUE_W-1:0] shadow_cells [SLE_DEPTH];
   logic [SLE_CNT_W-1:0]          shadow_count;
   logic [SLE_CNT_W-1:0]          shadow_capacity;
   list_result_type               pending_results [$];
   int                            errors = 0;

   // apply one operation to the shadow list and build its response
   task automatic apply_list_op(input logic [SLE_OPCODE_W-1:0] op,
                                input logic [SLE_POS_W-1:0] pos,
                                input logic signed [SLE_VALUE_W-1:0] val,
                                output list_result_type res);
      int limit;
      int cnt;
      int p;
      int k;
      logic hit;
      limit = (shadow_capacity > SLE_DEPTH) ? SLE_DEPTH : int'(shadow_capacity);
      cnt   = int'(shadow_count);
      p     = int'(pos);
      hit   = 1'b0;
      res.status         = SLE_ST_OK;
      res.value_out      = '0;
      res.found_position = '0;
      case (op)
         SLE_OP_GET: begin
            if (p < 1 || p > cnt) res.status = SLE_ST_RANGE;
            else res.value_out = shadow_cells[p-1];
         end
         SLE_OP_SET: begin
            if (p < 1 || p > cnt) res.status = SLE_ST_RANGE;
            else shadow_cells[p-1] = val;
         end
         SLE_OP_INSERT: begin
            if (p < 1 || p > cnt + 1) res.status = SLE_ST_RANGE;
            else if (cnt >= limit) res.status = SLE_ST_FULL;
            else begin
               // shift later entries up by one
               for (k = cnt; k >= p; k--) shadow_cells[k] = shadow_cells[k-1];
               shadow_cells[p-1] = val;
               cnt++;
            end
         end
         SLE_OP_DELETE: begin
            if (p < 1 || p > cnt) res.status = SLE_ST_RANGE;
            else begin
               res.value_out = shadow_cells[p-1];
               // close the gap
               for (k = p; k < cnt; k++) shadow_cells[k-1] = shadow_cells[k];
               cnt--;
            end
         end
         SLE_OP_LOCATE: begin
            res.status = SLE_ST_NOTFOUND;
            for (k = 0; k < cnt; k++) begin
               if (!hit && shadow_cells[k] == val) begin
                  hit = 1'b1;
                  res.found_position = SLE_POS_W'(k + 1);
                  res.status = SLE_ST_OK;
               end
            end
         end
         default: begin
            // unused opcodes leave everything alone
         end
      endcase
      shadow_count    = SLE_CNT_W'(cnt);
      res.entry_count = shadow_count;
   endtask

   task automatic report_mismatch(input string field, input logic signed [63:0] exp_v,
                                  input logic signed [63:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
   endtask

   // sample both channels and the csr port at every rising edge
   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         shadow_count    = '0;
         shadow_capacity = SLE_CNT_W'(SLE_DEPTH);
         pending_results.delete();
      end else begin
         if (csr_write_enable) shadow_capacity = csr_capacity_in_use;
         // request transfer: predict and queue
         if (req_valid && !req_stall) begin
            apply_list_op(req_opcode, req_position, req_value_in, want);
            pending_results.push_back(want);
         end
         // response transfer: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected", $time);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_value_out !== want.value_out)
                  report_mismatch("value_out", want.value_out, rsp_value_out);
               if (rsp_found_position !== want.found_position)
                  report_mismatch("found_position", want.found_position, rsp_found_position);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", want.entry_count, rsp_entry_count);
            end
         end
      end
      outstanding <= pending_results.size();
      fail_count  <= errors;
   end

endmodule

>>> sim/sequential_list_engine_tb.sv
// sequential_list_engine_tb: drives list operations and capacity writes into the engine,
// with random gaps on both channels and one long response hold-off
// depends on sle_pkg, sequential_list_engine and sle_list_checker
module sequential_list_engine_tb;
   import sle_pkg::*;

   localparam logic [SLE_OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [SLE_OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 170;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [SLE_OPCODE_W-1:0]       req_opcode;
   logic [SLE_POS_W-1:0]          req_position;
   logic signed [SLE_VALUE_W-1:0] req_value_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [SLE_STATUS_W-1:0]       rsp_status;
   logic signed [SLE_VALUE_W-1:0] rsp_value_out;
   logic [SLE_POS_W-1:0]          rsp_found_position;
   logic [SLE_CNT_W-1:0]          rsp_entry_count;
   logic                          csr_write_enable;
   logic [SLE_CNT_W-1:0]          csr_capacity_in_use;
   int                            fail_count;
   int                            outstanding;

   // stimulus bookkeeping: a count-only shadow used to aim positions
   int                            list_fill = 0;
   int                            capacity_now = SLE_DEPTH;
   int                            fill_peak = 0;
   int                            requests_sent = 0;
   int                            capacity_writes = 0;
   logic                          steady = 1'b0;
   logic signed [SLE_VALUE_W-1:0] value_pool [8];

   sequential_list_engine u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_value_out       (rsp_value_out),
      .rsp_found_position  (rsp_found_position),
      .rsp_entry_count     (rsp_entry_count),
      .csr_write_enable    (csr_write_enable),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   sle_list_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_value_out       (rsp_value_out),
      .rsp_found_position  (rsp_found_position),
      .rsp_entry_count     (rsp_entry_count),
      .csr_write_enable    (csr_write_enable),
      .csr_capacity_in_use (csr_capacity_in_use),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #8000000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stall per result, none in some windows, one long hold-off after 300 transfers
   initial begin : receiver
      int wait_n;
      int taken;
      logic held;
      taken = 0;
      held  = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
            if (!held && taken == 300) begin
               wait_n = 400;
               held   = 1'b1;
            end else if ((taken / 128) % 4 == 3) begin
               wait_n = 0;
            end else begin
               wait_n = $urandom_range(0, 10);
            end
            if (wait_n > 0) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
               while (!rsp_valid) @(posedge clock);
               repeat (wait_n - 1) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // offer one request, wait for its transfer, then an optional gap
   task automatic send_request(input logic [SLE_OPCODE_W-1:0] op,
                               input logic [SLE_POS_W-1:0] pos,
                               input logic signed [SLE_VALUE_W-1:0] val);
      int gap;
      int p;
      int limit;
      req_opcode   <= op;
      req_position <= pos;
      req_value_in <= val;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      // keep the count-only shadow in step
      p = int'(pos);
      limit = (capacity_now > SLE_DEPTH) ? SLE_DEPTH : capacity_now;
      if (op == SLE_OP_INSERT && p >= 1 && p <= list_fill + 1 && list_fill < limit)
         list_fill++;
      else if (op == SLE_OP_DELETE && p >= 1 && p <= list_fill)
         list_fill--;
      if (list_fill > fill_peak) fill_peak = list_fill;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait until every response has come back
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [SLE_CNT_W-1:0] cap);
      settle_idle();
      csr_capacity_in_use <= cap;
      csr_write_enable    <= 1'b1;
      @(posedge clock);
      csr_write_enable    <= 1'b0;
      capacity_now = int'(cap);
      capacity_writes++;
   endtask

   // mostly legal positions, with edges and out-of-range ones mixed in
   function automatic logic [SLE_POS_W-1:0] pick_position(input int span);
      int r;
      r = $urandom_range(0, 99);
      if (span == 0 || r < 8) return SLE_POS_W'($urandom_range(0, 127));
      if (r < 12) return SLE_POS_W'(1);
      if (r < 16) return SLE_POS_W'(span);
      return SLE_POS_W'($urandom_range(1, span));
   endfunction

   function automatic logic signed [SLE_VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // operation mix leans toward insert when growing, toward delete when shrinking
   function automatic logic [SLE_OPCODE_W-1:0] pick_op(input logic grow);
      int r;
      r = $urandom_range(0, 99);
      if (r < (grow ? 45 : 15)) return SLE_OP_INSERT;
      if (r < (grow ? 60 : 55)) return SLE_OP_DELETE;
      if (r < 70) return SLE_OP_GET;
      if (r < 82) return SLE_OP_SET;
      if (r < 97) return SLE_OP_LOCATE;
      case ($urandom_range(0, 2))
         0: return OP_SPARE_5;
         1: return OP_SPARE_6;
         default: return SLE_OP_NONE;
      endcase
   endfunction

   // stimulus
   initial begin : stimulus
      logic [SLE_CNT_W-1:0] phase_caps [PHASES];
      logic                 phase_grow [PHASES];
      logic [SLE_OPCODE_W-1:0] op;
      logic [SLE_POS_W-1:0]    pos;
      int phase;
      int n;
      phase_caps = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd64, 7'd40, 7'd64, 7'd2, 7'd100, 7'd64};
      phase_grow = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_opcode          <= '0;
      req_position        <= '0;
      req_value_in        <= '0;
      csr_write_enable    <= 1'b0;
      csr_capacity_in_use <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, field extremes, duplicates, bad positions, spare opcodes
      send_request(SLE_OP_GET,    7'd1,   32'sd0);
      send_request(SLE_OP_DELETE, 7'd1,   32'sd0);
      send_request(SLE_OP_LOCATE, 7'd0,   32'sd0);
      send_request(SLE_OP_INSERT, 7'd0,   32'sd5);
      send_request(SLE_OP_INSERT, 7'd2,   32'sd5);
      send_request(SLE_OP_INSERT, 7'd1,   32'h8000_0000);
      send_request(SLE_OP_INSERT, 7'd2,   32'h7fff_ffff);
      send_request(SLE_OP_INSERT, 7'd1,   -32'sd1);
      send_request(SLE_OP_INSERT, 7'd4,   32'sd0);
      send_request(SLE_OP_GET,    7'd1,   32'sd0);
      send_request(SLE_OP_GET,    7'd4,   32'sd0);
      send_request(SLE_OP_SET,    7'd2,   32'h5555_5555);
      send_request(SLE_OP_SET,    7'd5,   32'sd9);
      send_request(SLE_OP_SET,    7'd0,   32'sd9);
      send_request(SLE_OP_LOCATE, 7'd127, 32'h7fff_ffff);
      send_request(SLE_OP_LOCATE, 7'd0,   32'h1234_5678);
      send_request(SLE_OP_INSERT, 7'd3,   -32'sd1);
      send_request(SLE_OP_LOCATE, 7'd0,   -32'sd1);
      send_request(SLE_OP_DELETE, 7'd5,   32'sd0);
      send_request(SLE_OP_DELETE, 7'd1,   32'sd0);
      send_request(SLE_OP_DELETE, 7'd127, 32'sd0);
      send_request(SLE_OP_GET,    7'd65,  32'sd0);
      send_request(OP_SPARE_5,    7'd1,   32'sd7);
      send_request(OP_SPARE_6,    7'd127, -32'sd7);
      send_request(SLE_OP_NONE,   7'd2,   32'sd0);

      // random phases, one capacity setting each
      for (phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         steady = (phase % 3 == 2);
         value_pool[0] = 32'h8000_0000;
         value_pool[1] = 32'h7fff_ffff;
         for (n = 2; n < 8; n++) value_pool[n] = $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            op = pick_op(phase_grow[phase]);
            case (op)
               SLE_OP_INSERT: pos = pick_position(list_fill + 1);
               SLE_OP_GET, SLE_OP_SET, SLE_OP_DELETE: pos = pick_position(list_fill);
               default: pos = SLE_POS_W'($urandom_range(0, 127));
            endcase
            send_request(op, pos, pick_value());
         end
      end

      // drain, then let the row settle
      settle_idle();
      repeat (70) @(posedge clock);
      $display("run: %0d requests over %0d capacity settings, list peaked at %0d entries",
               requests_sent, capacity_writes, fill_peak);
      $display("run: included empty, full, zero-capacity and long response hold-off cases");
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
